// ===== src/eatm_pkg.sv =====
package eatm_pkg;

	// Angle resolution: a full turn is 2^ANGLE_BITS.
	localparam int ANGLE_BITS = 16;
	// Fraction bits of the Q16.16 style outputs and translations.
	localparam int FRAC_BITS = 16;
	// Default depth of the item queue between front and back.
	localparam int DEF_QUEUE_DEPTH = 8;

	// Pipeline depth of one sine unit, from angle to result register.
	localparam int SINE_LAT = 6;
	// Front latency: sine pipeline plus two product/round pairs and the final sums.
	localparam int FRONT_LAT = SINE_LAT + 5;

	// Model element: scale (Q8.8) times rotation (Q2.30) down to FRAC_BITS.
	localparam int MODEL_SHIFT = 38 - FRAC_BITS;
	// Normal element: numerator width before and after the 2^30 pre-divide.
	localparam int NUM_W = 41 + FRAC_BITS;
	localparam int DIV_W = FRAC_BITS + 11;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] COEF_A = 31'd1686629713;
	localparam logic [30:0] COEF_B = 31'd688904866;
	localparam logic [30:0] COEF_C = 31'd76016977;

	localparam logic [31:0] Q_ONE = 32'(1) << FRAC_BITS;
	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	// One request after the front: rotation (index column*3 + row, Q2.30 in 33 bits),
	// the raw scales and translations, and the matrix kind.
	typedef struct packed {
		logic normal;
		logic [8:0][32:0] rot;
		logic [2:0][15:0] scale;
		logic [2:0][31:0] move;
	} item_t;

	typedef enum logic [1:0] {
		COL_MODEL,
		COL_NORMAL,
		COL_ZERO,
		COL_MOVE
	} col_kind_t;

	typedef struct packed {
		col_kind_t kind;
		logic [1:0] col;
		logic last;
	} col_tag_t;

endpackage

// ===== src/eatm_sine.sv =====
module eatm_sine import eatm_pkg::*; (
	input logic clk,
	input logic [ANGLE_BITS-1:0] angle,
	output logic signed [31:0] sine
);

	localparam int QB = ANGLE_BITS - 2;

	logic [1:0] quad;
	logic [29:0] frac;
	logic [30:0] x_in;

	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4, quad_s5;
	logic [30:0] x_s1, x_s2, x_s3, x2_s3;
	logic [61:0] x2p_s2, x3p_s3, x5p_s4, ax_s4, bx3_s4;
	logic [61:0] ax_s5, bx3_s5, cx5_s5;
	logic signed [31:0] sine_s6;

	logic [30:0] x2, x3, x5;
	logic signed [63:0] poly;
	logic [33:0] poly_sh;
	logic [30:0] mag;
	logic [31:0] mag_w;

	// Odd quadrants run the quarter wave backwards.
	assign quad = angle[ANGLE_BITS-1 -: 2];
	assign frac = {angle[QB-1:0], {(32 - ANGLE_BITS){1'b0}}};
	assign x_in = quad[0] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};

	// Powers are truncated back to Q30.
	assign x2 = x2p_s2[60:30];
	assign x3 = x3p_s3[60:30];
	assign x5 = x5p_s4[60:30];

	assign poly = $signed({2'b00, ax_s5}) + $signed({2'b00, cx5_s5})
		- $signed({2'b00, bx3_s5});
	assign poly_sh = poly[63] ? '0 : poly[63:30];
	assign mag = (poly_sh > 34'(Q30_ONE)) ? Q30_ONE : poly_sh[30:0];
	assign mag_w = {1'b0, mag};

	always_ff @(posedge clk) begin
		quad_s1 <= quad;
		x_s1 <= x_in;

		quad_s2 <= quad_s1;
		x_s2 <= x_s1;
		x2p_s2 <= x_s1 * x_s1;

		quad_s3 <= quad_s2;
		x_s3 <= x_s2;
		x2_s3 <= x2;
		x3p_s3 <= x2 * x_s2;

		quad_s4 <= quad_s3;
		x5p_s4 <= x3 * x2_s3;
		ax_s4 <= COEF_A * x_s3;
		bx3_s4 <= COEF_B * x3;

		quad_s5 <= quad_s4;
		ax_s5 <= ax_s4;
		bx3_s5 <= bx3_s4;
		cx5_s5 <= COEF_C * x5;

		sine_s6 <= quad_s5[1] ? $signed(32'd0 - mag_w) : $signed(mag_w);
	end

	assign sine = sine_s6;

endmodule

// ===== src/eatm_front.sv =====
module eatm_front import eatm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic command,
	input logic signed [15:0] angle_x,
	input logic signed [15:0] angle_y,
	input logic signed [15:0] angle_z,
	input logic signed [15:0] scale_x,
	input logic signed [15:0] scale_y,
	input logic signed [15:0] scale_z,
	input logic signed [31:0] move_x,
	input logic signed [31:0] move_y,
	input logic signed [31:0] move_z,
	output logic out_valid,
	output item_t out_item
);

	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	typedef struct packed {
		logic normal;
		logic [2:0][15:0] scale;
		logic [2:0][31:0] move;
	} side_t;

	// Products of two Q30 values, rounded half away from zero.
	function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
		logic [63:0] t;
		t = p + 64'h2000_0000 - 64'(p[63]);
		return t[61:30];
	endfunction

	logic signed [31:0] ax_w, ay_w, az_w;
	logic [5:0][ANGLE_BITS-1:0] ang;
	logic signed [31:0] sn [6];
	side_t side_in;

	logic [FRONT_LAT-1:0] vld_sk;
	side_t side_sk [FRONT_LAT];

	logic signed [63:0] sysx_s7, cysx_s7, cycz_s7, cxsz_s7, czsy_s7;
	logic signed [63:0] cxcz_s7, sysz_s7, cxsy_s7, cycx_s7, cysz_s7;
	logic signed [31:0] sx_s7, sz_s7, cz_s7;

	logic signed [31:0] sysx_s8, cysx_s8, cycz_s8, cxsz_s8, czsy_s8;
	logic signed [31:0] cxcz_s8, sysz_s8, cxsy_s8, cycx_s8, cysz_s8;
	logic signed [31:0] sx_s8, sz_s8, cz_s8;

	logic signed [63:0] sysxsz_s9, czsysx_s9, cysxsz_s9, cysxcz_s9;
	logic signed [31:0] cycz_s9, cxsz_s9, czsy_s9, cxcz_s9, sysz_s9;
	logic signed [31:0] cxsy_s9, cycx_s9, cysz_s9, sx_s9;

	logic signed [31:0] sysxsz_s10, czsysx_s10, cysxsz_s10, cysxcz_s10;
	logic signed [31:0] cycz_s10, cxsz_s10, czsy_s10, cxcz_s10, sysz_s10;
	logic signed [31:0] cxsy_s10, cycx_s10, cysz_s10, sx_s10;

	logic [8:0][32:0] rot_s11;

	assign ax_w = 32'(angle_x);
	assign ay_w = 32'(angle_y);
	assign az_w = 32'(angle_z);

	// Unit order: sin x, cos x, sin y, cos y, sin z, cos z.
	assign ang[0] = ax_w[ANGLE_BITS-1:0];
	assign ang[1] = ax_w[ANGLE_BITS-1:0] + QUARTER;
	assign ang[2] = ay_w[ANGLE_BITS-1:0];
	assign ang[3] = ay_w[ANGLE_BITS-1:0] + QUARTER;
	assign ang[4] = az_w[ANGLE_BITS-1:0];
	assign ang[5] = az_w[ANGLE_BITS-1:0] + QUARTER;

	for (genvar g = 0; g < 6; g++) begin : g_sine
		eatm_sine u_sine (
			.clk(clk),
			.angle(ang[g]),
			.sine(sn[g])
		);
	end

	assign side_in.normal = command;
	assign side_in.scale = {scale_z, scale_y, scale_x};
	assign side_in.move = {move_z, move_y, move_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else begin
			vld_sk <= {vld_sk[FRONT_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		side_sk[0] <= side_in;
		for (int i = 1; i < FRONT_LAT; i++) begin
			side_sk[i] <= side_sk[i-1];
		end

		// Sine order: sn[0] sx, sn[1] cx, sn[2] sy, sn[3] cy, sn[4] sz, sn[5] cz.
		sysx_s7 <= sn[2] * sn[0];
		cysx_s7 <= sn[3] * sn[0];
		cycz_s7 <= sn[3] * sn[5];
		cxsz_s7 <= sn[1] * sn[4];
		czsy_s7 <= sn[5] * sn[2];
		cxcz_s7 <= sn[1] * sn[5];
		sysz_s7 <= sn[2] * sn[4];
		cxsy_s7 <= sn[1] * sn[2];
		cycx_s7 <= sn[3] * sn[1];
		cysz_s7 <= sn[3] * sn[4];
		sx_s7 <= sn[0];
		sz_s7 <= sn[4];
		cz_s7 <= sn[5];

		sysx_s8 <= rnd_q30(sysx_s7);
		cysx_s8 <= rnd_q30(cysx_s7);
		cycz_s8 <= rnd_q30(cycz_s7);
		cxsz_s8 <= rnd_q30(cxsz_s7);
		czsy_s8 <= rnd_q30(czsy_s7);
		cxcz_s8 <= rnd_q30(cxcz_s7);
		sysz_s8 <= rnd_q30(sysz_s7);
		cxsy_s8 <= rnd_q30(cxsy_s7);
		cycx_s8 <= rnd_q30(cycx_s7);
		cysz_s8 <= rnd_q30(cysz_s7);
		sx_s8 <= sx_s7;
		sz_s8 <= sz_s7;
		cz_s8 <= cz_s7;

		sysxsz_s9 <= sysx_s8 * sz_s8;
		czsysx_s9 <= cz_s8 * sysx_s8;
		cysxsz_s9 <= cysx_s8 * sz_s8;
		cysxcz_s9 <= cysx_s8 * cz_s8;
		cycz_s9 <= cycz_s8;
		cxsz_s9 <= cxsz_s8;
		czsy_s9 <= czsy_s8;
		cxcz_s9 <= cxcz_s8;
		sysz_s9 <= sysz_s8;
		cxsy_s9 <= cxsy_s8;
		cycx_s9 <= cycx_s8;
		cysz_s9 <= cysz_s8;
		sx_s9 <= sx_s8;

		sysxsz_s10 <= rnd_q30(sysxsz_s9);
		czsysx_s10 <= rnd_q30(czsysx_s9);
		cysxsz_s10 <= rnd_q30(cysxsz_s9);
		cysxcz_s10 <= rnd_q30(cysxcz_s9);
		cycz_s10 <= cycz_s9;
		cxsz_s10 <= cxsz_s9;
		czsy_s10 <= czsy_s9;
		cxcz_s10 <= cxcz_s9;
		sysz_s10 <= sysz_s9;
		cxsy_s10 <= cxsy_s9;
		cycx_s10 <= cycx_s9;
		cysz_s10 <= cysz_s9;
		sx_s10 <= sx_s9;

		rot_s11[0] <= 33'(cycz_s10) + 33'(sysxsz_s10);
		rot_s11[1] <= 33'(cxsz_s10);
		rot_s11[2] <= 33'(cysxsz_s10) - 33'(czsy_s10);
		rot_s11[3] <= 33'(czsysx_s10) - 33'(cysz_s10);
		rot_s11[4] <= 33'(cxcz_s10);
		rot_s11[5] <= 33'(cysxcz_s10) + 33'(sysz_s10);
		rot_s11[6] <= 33'(cxsy_s10);
		rot_s11[7] <= 33'd0 - 33'(sx_s10);
		rot_s11[8] <= 33'(cycx_s10);
	end

	assign out_valid = vld_sk[FRONT_LAT-1];
	assign out_item.normal = side_sk[FRONT_LAT-1].normal;
	assign out_item.rot = rot_s11;
	assign out_item.scale = side_sk[FRONT_LAT-1].scale;
	assign out_item.move = side_sk[FRONT_LAT-1].move;

endmodule

// ===== src/eatm_queue.sv =====
module eatm_queue import eatm_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t push_item,
	input logic pop,
	output item_t head,
	output logic not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);

endmodule

// ===== src/eatm_back.sv =====
module eatm_back import eatm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input item_t head,
	input logic not_empty,
	output logic pop,
	output logic valid,
	output logic [1:0] column_index,
	output logic signed [31:0] row0,
	output logic signed [31:0] row1,
	output logic signed [31:0] row2,
	output logic signed [31:0] row3,
	output logic zero_scale,
	output logic last
);

	localparam logic signed [49:0] SAT_HI = 50'sh7FFF_FFFF;
	localparam logic signed [49:0] SAT_LO = -50'sh8000_0000;

	typedef struct packed {
		col_tag_t tag;
		logic [15:0] ms;
		logic [2:0] neg;
		logic [2:0] rz;
		logic [2:0][31:0] fin;
	} dv_ctl_t;

	// One restoring step: next quotient bit from the partial remainder.
	function automatic logic [17+DIV_W-1:0] div_step(input logic [16:0] rem,
		input logic [DIV_W-1:0] dq, input logic [15:0] ms);
		logic [16:0] pre;
		logic ge;
		logic [16:0] nrem;
		pre = {rem[15:0], dq[DIV_W-1]};
		ge = (pre >= {1'b0, ms});
		nrem = ge ? (pre - {1'b0, ms}) : pre;
		return {nrem, dq[DIV_W-2:0], ge};
	endfunction

	logic [1:0] col_q;
	logic col_last;
	logic [1:0] csel;
	col_kind_t kind;
	logic signed [32:0] rot_sel [3];

	logic v_s1, v_s2;
	col_tag_t tag_s1, tag_s2;
	logic signed [15:0] scale_s1;
	logic signed [32:0] rot_s1 [3];
	logic [2:0][31:0] move_s1, move_s2;

	logic signed [48:0] prod_s2 [3];
	logic [DIV_W-1:0] num_s2 [3];
	logic [15:0] ms_s2;
	logic [2:0] neg_s2, rz_s2, rpos_s2;

	logic [15:0] ms_c;
	logic [32:0] mag_c [3];
	logic [31:0] mr_c [3];
	logic [NUM_W-1:0] nw_c [3];

	logic signed [49:0] rt_c [3];
	logic signed [49:0] rr_c [3];
	logic [2:0][31:0] fin_c;

	logic dv_v_s [DIV_W+1];
	dv_ctl_t dv_ctl_s [DIV_W+1];
	logic [16:0] dv_rem_s [DIV_W+1][3];
	logic [DIV_W-1:0] dv_dq_s [DIV_W+1][3];

	logic [63:0] qx_c [3];
	logic [2:0][31:0] res_c;

	logic valid_q, zero_scale_q, last_q;
	logic [1:0] column_index_q;
	logic [31:0] row_q [4];

	// Column issue: one column of the head item per cycle while the queue is not empty.
	assign col_last = head.normal ? (col_q == 2'd2) : (col_q == 2'd3);
	assign pop = not_empty & col_last;
	assign csel = (col_q == 2'd3) ? 2'd0 : col_q;

	always_comb begin
		if (col_q == 2'd3) begin
			kind = COL_MOVE;
		end else if (!head.normal) begin
			kind = COL_MODEL;
		end else if (head.scale[csel] == '0) begin
			kind = COL_ZERO;
		end else begin
			kind = COL_NORMAL;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rot_sel[r] = $signed(head.rot[4'(csel) * 4'd3 + 4'(r)]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_q <= 1'b0;
			for (int k = 0; k <= DIV_W; k++) begin
				dv_v_s[k] <= 1'b0;
			end
		end else begin
			if (not_empty) begin
				col_q <= col_last ? 2'd0 : col_q + 2'd1;
			end
			v_s1 <= not_empty;
			v_s2 <= v_s1;
			dv_v_s[0] <= v_s2;
			for (int k = 1; k <= DIV_W; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
			valid_q <= dv_v_s[DIV_W];
		end
	end

	// Magnitudes and the pre-divided numerator for the normal matrix.
	assign ms_c = scale_s1[15] ? (16'd0 - scale_s1) : scale_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = rot_s1[i][32] ? (33'd0 - rot_s1[i]) : rot_s1[i];
			mr_c[i] = (mag_c[i] > 33'h8000_0000) ? 32'h8000_0000 : mag_c[i][31:0];
			nw_c[i] = (NUM_W'(mr_c[i]) << (8 + FRAC_BITS)) + (NUM_W'(ms_c) << 29);
		end
	end

	// Model rounding and saturation, and the values of columns that skip the divider.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt_c[i] = 50'(prod_s2[i]) + (50'(1) << (MODEL_SHIFT - 1))
				- 50'(prod_s2[i][48]);
			rr_c[i] = rt_c[i] >>> MODEL_SHIFT;
			case (tag_s2.kind)
				COL_MOVE: fin_c[i] = move_s2[i];
				COL_MODEL: begin
					if (rr_c[i] > SAT_HI) begin
						fin_c[i] = S32_MAX;
					end else if (rr_c[i] < SAT_LO) begin
						fin_c[i] = S32_MIN;
					end else begin
						fin_c[i] = rr_c[i][31:0];
					end
				end
				COL_ZERO: fin_c[i] = rpos_s2[i] ? S32_MAX : (rz_s2[i] ? '0 : S32_MIN);
				default: fin_c[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.kind <= kind;
		tag_s1.col <= col_q;
		tag_s1.last <= col_last;
		scale_s1 <= $signed(head.scale[csel]);
		move_s1 <= head.move;
		for (int r = 0; r < 3; r++) begin
			rot_s1[r] <= rot_sel[r];
		end

		tag_s2 <= tag_s1;
		move_s2 <= move_s1;
		ms_s2 <= ms_c;
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= 49'(scale_s1) * 49'(rot_s1[i]);
			num_s2[i] <= nw_c[i][NUM_W-1:30];
			neg_s2[i] <= rot_s1[i][32] ^ scale_s1[15];
			rz_s2[i] <= (rot_s1[i] == '0);
			rpos_s2[i] <= !rot_s1[i][32] && (rot_s1[i] != '0);
		end

		dv_ctl_s[0].tag <= tag_s2;
		dv_ctl_s[0].ms <= ms_s2;
		dv_ctl_s[0].neg <= neg_s2;
		dv_ctl_s[0].rz <= rz_s2;
		dv_ctl_s[0].fin <= fin_c;
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= '0;
			dv_dq_s[0][i] <= num_s2[i];
		end

		for (int k = 1; k <= DIV_W; k++) begin
			dv_ctl_s[k] <= dv_ctl_s[k-1];
			for (int i = 0; i < 3; i++) begin
				{dv_rem_s[k][i], dv_dq_s[k][i]} <= div_step(dv_rem_s[k-1][i],
					dv_dq_s[k-1][i], dv_ctl_s[k-1].ms);
			end
		end
	end

	// Sign and saturation of the quotients.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qx_c[i] = 64'(dv_dq_s[DIV_W][i]);
			if (dv_ctl_s[DIV_W].tag.kind != COL_NORMAL) begin
				res_c[i] = dv_ctl_s[DIV_W].fin[i];
			end else if (dv_ctl_s[DIV_W].rz[i]) begin
				res_c[i] = '0;
			end else if (dv_ctl_s[DIV_W].neg[i]) begin
				res_c[i] = (qx_c[i] > 64'h8000_0000) ? S32_MIN : (32'd0 - qx_c[i][31:0]);
			end else begin
				res_c[i] = (qx_c[i] > 64'h7FFF_FFFF) ? S32_MAX : qx_c[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		column_index_q <= dv_ctl_s[DIV_W].tag.col;
		last_q <= dv_ctl_s[DIV_W].tag.last;
		zero_scale_q <= (dv_ctl_s[DIV_W].tag.kind == COL_ZERO);
		for (int i = 0; i < 3; i++) begin
			row_q[i] <= res_c[i];
		end
		row_q[3] <= (dv_ctl_s[DIV_W].tag.kind == COL_MOVE) ? Q_ONE : '0;
	end

	assign valid = valid_q;
	assign column_index = column_index_q;
	assign row0 = $signed(row_q[0]);
	assign row1 = $signed(row_q[1]);
	assign row2 = $signed(row_q[2]);
	assign row3 = $signed(row_q[3]);
	assign zero_scale = zero_scale_q;
	assign last = last_q;

endmodule

// ===== src/euler_affine_transform_matrix.sv =====
// Column 0 of a request passes the front pipeline, the queue count register, the back
// issue stages, the divider and the output register when the queue is empty. The back
// end sets the pace and cannot be stalled: one column beat per cycle while the queue
// is not empty, four columns for a model request and three for a normal one.
// Reset: arst_n clears all control state at once; no clearing pass is needed.
module euler_affine_transform_matrix import eatm_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic command,
	input logic signed [15:0] angle_x,
	input logic signed [15:0] angle_y,
	input logic signed [15:0] angle_z,
	input logic signed [15:0] scale_x,
	input logic signed [15:0] scale_y,
	input logic signed [15:0] scale_z,
	input logic signed [31:0] move_x,
	input logic signed [31:0] move_y,
	input logic signed [31:0] move_z,
	output logic valid,
	output logic [1:0] column_index,
	output logic signed [31:0] row0,
	output logic signed [31:0] row1,
	output logic signed [31:0] row2,
	output logic signed [31:0] row3,
	output logic zero_scale,
	output logic last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// The block is split in two. The front takes a request beat every cycle
	// unless busy, runs six sine units and the rotation products in a fixed-length
	// pipeline that never stalls, and drops the finished item into a queue. The back
	// pops items and emits one column beat per cycle through a pipelined divider that
	// serves the normal matrix; model and translation columns ride alongside it
	// so that every column has the same latency and order is kept.

	logic accept;
	logic front_valid;
	item_t front_item;
	item_t head;
	logic not_empty;
	logic pop;

	// Every accepted request holds a credit until the back pops it, so the
	// front can never push into a full queue even though it cannot stall.
	logic [CW-1:0] credit_q;

	assign accept = start & ~busy;
	assign busy = (credit_q == CW'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10: credit_q <= credit_q + 1'b1;
				2'b01: credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	eatm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(command),
		.angle_x(angle_x),
		.angle_y(angle_y),
		.angle_z(angle_z),
		.scale_x(scale_x),
		.scale_y(scale_y),
		.scale_z(scale_z),
		.move_x(move_x),
		.move_y(move_y),
		.move_z(move_z),
		.out_valid(front_valid),
		.out_item(front_item)
	);

	eatm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_valid),
		.push_item(front_item),
		.pop(pop),
		.head(head),
		.not_empty(not_empty)
	);

	// The back walks the head item column by column and releases it with the
	// last column, which also returns its credit.
	eatm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.not_empty(not_empty),
		.pop(pop),
		.valid(valid),
		.column_index(column_index),
		.row0(row0),
		.row1(row1),
		.row2(row2),
		.row3(row3),
		.zero_scale(zero_scale),
		.last(last)
	);

	// Columns of one matrix leave on consecutive cycles, in order.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid && (column_index == $past(column_index) + 2'd1))
		else $error("column beats of one matrix are not back to back");

	// After the last column a new matrix starts at column zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid || (column_index == 2'd0))
		else $error("new matrix does not start at column zero");

	// The translation column is always last and carries w of one.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && (column_index == 2'd3) |-> last && (row3 == $signed(Q_ONE)))
		else $error("translation column malformed");

	// A zero-scale flag only appears on a rotation column of the normal matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && zero_scale |-> (column_index != 2'd3) && (row3 == '0))
		else $error("zero scale flag on a translation column");

endmodule
